FILE: hdl/vab_pkg.sv
`timescale 1ns / 1ps

package vab_pkg;

  // Status of one queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // CORDIC rotation angles, round(atan(2^-k) * 2^32 / pi).
  localparam int AtanWidth = 31;

  function automatic logic [AtanWidth-1:0] atan_unit(input logic [4:0] k);
    logic [AtanWidth-1:0] r;
    case (k)
      5'd0:  r = 31'd1073741824;
      5'd1:  r = 31'd633866811;
      5'd2:  r = 31'd334917814;
      5'd3:  r = 31'd170009512;
      5'd4:  r = 31'd85334662;
      5'd5:  r = 31'd42708931;
      5'd6:  r = 31'd21359677;
      5'd7:  r = 31'd10680490;
      5'd8:  r = 31'd5340327;
      5'd9:  r = 31'd2670173;
      5'd10: r = 31'd1335088;
      5'd11: r = 31'd667544;
      5'd12: r = 31'd333772;
      5'd13: r = 31'd166886;
      5'd14: r = 31'd83443;
      5'd15: r = 31'd41722;
      5'd16: r = 31'd20861;
      5'd17: r = 31'd10430;
      5'd18: r = 31'd5215;
      5'd19: r = 31'd2608;
      5'd20: r = 31'd1304;
      5'd21: r = 31'd652;
      5'd22: r = 31'd326;
      5'd23: r = 31'd163;
      5'd24: r = 31'd81;
      5'd25: r = 31'd41;
      5'd26: r = 31'd20;
      5'd27: r = 31'd10;
      5'd28: r = 31'd5;
      5'd29: r = 31'd3;
      5'd30: r = 31'd1;
      5'd31: r = 31'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/vector_angle_between.sv
`timescale 1ns / 1ps

// Angle between two 3D integer vectors, atan2(|a x b|, a . b), scaled so that
// 2^ANGLE_FRACTION_BITS means pi. One request is taken every cycle while the
// middle queue has room. The back end runs a 32-stage bit-per-stage square
// root and one pipeline stage per CORDIC step.
// A four-entry queue sits between the product front end and the angle back
// end, and a four-entry queue holds finished results.
module vector_angle_between import vab_pkg::*; #(
  parameter int COMPONENT_WIDTH     = 16,
  parameter int ANGLE_FRACTION_BITS = 15,
  parameter int CORDIC_STEPS        = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [COMPONENT_WIDTH-1:0] first_x,
  input  logic signed [COMPONENT_WIDTH-1:0] first_y,
  input  logic signed [COMPONENT_WIDTH-1:0] first_z,
  input  logic signed [COMPONENT_WIDTH-1:0] second_x,
  input  logic signed [COMPONENT_WIDTH-1:0] second_y,
  input  logic signed [COMPONENT_WIDTH-1:0] second_z,
  output logic                              empty,
  input  logic                              pop,
  output logic [15:0]                       angle
);

  localparam int IW = 8 * COMPONENT_WIDTH + 1;

  queue_status_t   mid;
  queue_status_t   outq;
  logic            item_push;
  logic [IW-1:0]   item_in;
  logic [IW-1:0]   item_out;
  logic            mid_pop;
  logic            res_push;
  logic [15:0]     res;

  vab_front #(.W(COMPONENT_WIDTH)) u_front (
    .clk, .rst, .push, .full,
    .first_x, .first_y, .first_z, .second_x, .second_y, .second_z,
    .mid, .item_push, .item(item_in)
  );

  vab_queue #(.WIDTH(IW), .DEPTH(4)) u_mid (
    .clk, .rst, .push(item_push), .din(item_in),
    .pop(mid_pop), .dout(item_out), .status(mid)
  );

  vab_back #(
    .W(COMPONENT_WIDTH), .F(ANGLE_FRACTION_BITS), .STEPS(CORDIC_STEPS)
  ) u_back (
    .clk, .rst, .mid, .item(item_out), .mid_pop,
    .outq, .res_push, .res
  );

  vab_queue #(.WIDTH(16), .DEPTH(4)) u_out (
    .clk, .rst, .push(res_push), .din(res),
    .pop, .dout(angle), .status(outq)
  );

  assign empty = outq.empty;

endmodule

FILE: hdl/vab_queue.sv
`timescale 1ns / 1ps

module vab_queue import vab_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output queue_status_t    status
);

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntWidth = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign status.full  = (count == CntWidth'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign dout         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntWidth'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !status.full && !(pop && !status.empty)) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on a lone push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !status.empty && !(push && !status.full)) |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on a lone pop");

endmodule

FILE: hdl/vab_front.sv
`timescale 1ns / 1ps

module vab_front import vab_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic signed [W-1:0] first_x,
  input  logic signed [W-1:0] first_y,
  input  logic signed [W-1:0] first_z,
  input  logic signed [W-1:0] second_x,
  input  logic signed [W-1:0] second_y,
  input  logic signed [W-1:0] second_z,
  input  queue_status_t       mid,
  output logic                item_push,
  output logic [8*W:0]        item
);

  localparam int MW = 2 * W;

  logic          en;
  logic [3:0]    v;

  // Stage 1: sign and magnitude of each component.
  logic [W-1:0]  ma [3];
  logic [W-1:0]  mb [3];
  logic [2:0]    na;
  logic [2:0]    nb;

  // Stage 2: the nine partial products and their signs.
  logic [MW-1:0] p [9];
  logic [8:0]    s;

  // Stage 3: positive and negative sums for the three cross terms and the dot.
  logic [MW-1:0] pos [4];
  logic [MW-1:0] neg [4];

  // Stage 4: settled magnitudes.
  logic [MW-1:0] mag [4];
  logic          nd;

  logic [W-1:0]  in_a [3];
  logic [W-1:0]  in_b [3];

  assign en        = !v[3] || !mid.full;
  assign full      = !en;
  assign item_push = v[3];
  assign item      = {nd, mag[3], mag[2], mag[1], mag[0]};

  assign in_a[0] = first_x;
  assign in_a[1] = first_y;
  assign in_a[2] = first_z;
  assign in_b[0] = second_x;
  assign in_b[1] = second_y;
  assign in_b[2] = second_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        na[i] <= in_a[i][W-1];
        nb[i] <= in_b[i][W-1];
        ma[i] <= in_a[i][W-1] ? (~in_a[i] + W'(1)) : in_a[i];
        mb[i] <= in_b[i][W-1] ? (~in_b[i] + W'(1)) : in_b[i];
      end

      p[0] <= MW'(ma[1]) * MW'(mb[2]);
      s[0] <= na[1] ^ nb[2];
      p[1] <= MW'(mb[1]) * MW'(ma[2]);
      s[1] <= ~(nb[1] ^ na[2]);
      p[2] <= MW'(mb[0]) * MW'(ma[2]);
      s[2] <= nb[0] ^ na[2];
      p[3] <= MW'(ma[0]) * MW'(mb[2]);
      s[3] <= ~(na[0] ^ nb[2]);
      p[4] <= MW'(ma[0]) * MW'(mb[1]);
      s[4] <= na[0] ^ nb[1];
      p[5] <= MW'(mb[0]) * MW'(ma[1]);
      s[5] <= ~(nb[0] ^ na[1]);
      for (int i = 0; i < 3; i++) begin
        p[6+i] <= MW'(ma[i]) * MW'(mb[i]);
        s[6+i] <= na[i] ^ nb[i];
      end

      for (int c = 0; c < 3; c++) begin
        pos[c] <= (s[2*c] ? '0 : p[2*c]) + (s[2*c+1] ? '0 : p[2*c+1]);
        neg[c] <= (s[2*c] ? p[2*c] : '0) + (s[2*c+1] ? p[2*c+1] : '0);
      end
      pos[3] <= (s[6] ? '0 : p[6]) + (s[7] ? '0 : p[7]) + (s[8] ? '0 : p[8]);
      neg[3] <= (s[6] ? p[6] : '0) + (s[7] ? p[7] : '0) + (s[8] ? p[8] : '0);

      for (int c = 0; c < 4; c++) begin
        mag[c] <= (pos[c] >= neg[c]) ? pos[c] - neg[c] : neg[c] - pos[c];
      end
      nd <= (neg[3] > pos[3]);
    end
  end

endmodule

FILE: hdl/vab_back.sv
`timescale 1ns / 1ps

module vab_back import vab_pkg::*; #(
  parameter int W     = 16,
  parameter int F     = 15,
  parameter int STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t mid,
  input  logic [8*W:0]  item,
  output logic          mid_pop,
  input  queue_status_t outq,
  output logic          res_push,
  output logic [15:0]   res
);

  localparam int MW    = 2 * W;
  localparam int NCH   = (MW + 7) / 8;
  localparam int LW    = $clog2(MW + 1);
  localparam int XW    = 36;
  localparam int ZW    = 36;
  localparam int SH    = 32 - F;
  localparam int SQ    = 32;
  // Front stages: chunk scan, length, shift, squares, sum.
  localparam int NPRE  = 5;
  localparam int NST   = NPRE + SQ + 1 + STEPS + 1;

  logic           en;
  logic [NST-1:0] v;
  logic [MW-1:0]  in_mag [4];
  logic           in_nd;

  assign en       = !v[NST-1] || !outq.full;
  assign mid_pop  = en && !mid.empty;
  assign res_push = v[NST-1];

  assign in_mag[0] = item[MW-1:0];
  assign in_mag[1] = item[2*MW-1:MW];
  assign in_mag[2] = item[3*MW-1:2*MW];
  assign in_mag[3] = item[4*MW-1:3*MW];
  assign in_nd     = item[4*MW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], !mid.empty};
    end
  end

  // Stage 1: leading one per byte of the OR of all four magnitudes.
  logic [MW-1:0]  s1_mag [4];
  logic           s1_nd;
  logic [NCH-1:0] s1_any;
  logic [2:0]     s1_pos [NCH];
  logic [NCH*8-1:0] orv;

  always_comb begin
    orv = '0;
    orv[MW-1:0] = in_mag[0] | in_mag[1] | in_mag[2] | in_mag[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag <= in_mag;
      s1_nd  <= in_nd;
      for (int c = 0; c < NCH; c++) begin
        s1_any[c] <= |orv[c*8 +: 8];
        s1_pos[c] <= '0;
        for (int b = 0; b < 8; b++) begin
          if (orv[c*8+b]) begin
            s1_pos[c] <= 3'(b);
          end
        end
      end
    end
  end

  // Stage 2: bit length of the largest magnitude.
  logic [MW-1:0] s2_mag [4];
  logic          s2_nd;
  logic [LW-1:0] s2_len;
  logic          s2_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag  <= s1_mag;
      s2_nd   <= s1_nd;
      s2_zero <= ~|s1_any;
      s2_len  <= '0;
      for (int c = 0; c < NCH; c++) begin
        if (s1_any[c]) begin
          s2_len <= LW'(c * 8) + LW'(s1_pos[c]) + LW'(1);
        end
      end
    end
  end

  // Stage 3: scale so that the largest magnitude fills bits 30..0.
  logic [30:0] s3_mag [4];
  logic        s3_nd;
  logic        s3_zero;
  logic [MW+30:0] wide [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      wide[c] = {s2_mag[c], 31'b0} >> s2_len;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        s3_mag[c] <= wide[c][30:0];
      end
      s3_nd   <= s2_nd;
      s3_zero <= s2_zero;
    end
  end

  // Stage 4: squares of the cross terms. Stage 5: their sum.
  logic [61:0] s4_sq [3];
  logic [30:0] s4_d;
  logic        s4_nd;
  logic        s4_zero;
  logic [63:0] s5_sum;
  logic [30:0] s5_d;
  logic        s5_nd;
  logic        s5_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s4_sq[c] <= 62'(s3_mag[c]) * 62'(s3_mag[c]);
      end
      s4_d    <= s3_mag[3];
      s4_nd   <= s3_nd;
      s4_zero <= s3_zero;
      s5_sum  <= 64'(s4_sq[0]) + 64'(s4_sq[1]) + 64'(s4_sq[2]);
      s5_d    <= s4_d;
      s5_nd   <= s4_nd;
      s5_zero <= s4_zero;
    end
  end

  // Square root, one result bit per stage.
  logic [63:0] q_rad  [SQ+1];
  logic [32:0] q_rem  [SQ+1];
  logic [31:0] q_root [SQ+1];
  logic [30:0] q_d    [SQ+1];
  logic        q_nd   [SQ+1];
  logic        q_zero [SQ+1];

  assign q_rad[0]  = s5_sum;
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;
  assign q_d[0]    = s5_d;
  assign q_nd[0]   = s5_nd;
  assign q_zero[0] = s5_zero;

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [34:0] rem_s;
    logic [34:0] trial;
    assign rem_s = {q_rem[j], q_rad[j][63:62]};
    assign trial = {1'b0, q_root[j], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        q_rad[j+1]  <= {q_rad[j][61:0], 2'b00};
        q_d[j+1]    <= q_d[j];
        q_nd[j+1]   <= q_nd[j];
        q_zero[j+1] <= q_zero[j];
        if (rem_s >= trial) begin
          q_rem[j+1]  <= 33'(rem_s - trial);
          q_root[j+1] <= {q_root[j][30:0], 1'b1};
        end else begin
          q_rem[j+1]  <= rem_s[32:0];
          q_root[j+1] <= {q_root[j][30:0], 1'b0};
        end
      end
    end
  end

  // CORDIC vectoring; a negative dot is first rotated by a quarter turn.
  logic signed [XW-1:0] cx [STEPS+1];
  logic signed [XW-1:0] cy [STEPS+1];
  logic signed [ZW-1:0] cz [STEPS+1];
  logic                 czero [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      czero[0] <= q_zero[SQ];
      if (q_nd[SQ]) begin
        cx[0] <= XW'(q_root[SQ]);
        cy[0] <= XW'(q_d[SQ]);
        cz[0] <= ZW'(64'd2147483648);
      end else begin
        cx[0] <= XW'(q_d[SQ]);
        cy[0] <= XW'(q_root[SQ]);
        cz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    localparam logic [4:0] K = 5'(i % 32);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;
    assign dx = cy[i] >>> K;
    assign dy = cx[i] >>> K;
    assign da = ZW'(atan_unit(K));
    always_ff @(posedge clk) begin
      if (en) begin
        czero[i+1] <= czero[i];
        if (!cy[i][XW-1]) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + da;
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - da;
        end
      end
    end
  end

  // Round half up to the angle format and clamp to the range 0 to pi.
  logic [ZW-1:0] zc;
  logic [ZW-1:0] rounded;
  localparam logic [ZW-1:0] Full = ZW'(1) << F;

  assign zc      = cz[STEPS][ZW-1] ? '0 : cz[STEPS];
  assign rounded = (zc + (ZW'(1) << (SH - 1))) >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      if (czero[STEPS]) begin
        res <= '0;
      end else if (rounded > Full) begin
        res <= Full[15:0];
      end else begin
        res <= rounded[15:0];
      end
    end
  end

endmodule

FILE: verif/angle_checker.sv
`timescale 1ns / 1ps

module angle_checker import vab_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] first_z,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  input  logic signed [15:0] second_z,
  input  logic               empty,
  input  logic               pop,
  input  logic [15:0]        angle,
  output int                 failures,
  output int                 pending
);

  localparam int FracBits = 15;
  localparam int Steps = 16;

  logic [15:0] expected_angles[$];

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [15:0] predict_angle(
      longint ax, longint ay, longint az, longint bx, longint by, longint bz);
    longint c[3];
    longint d, top, length, sumsq, x, y, z, dx, dy, rnd, res, t;
    longint unsigned mag[4];
    longint unsigned sq, bitv, r;
    int len;
    c[0] = ay * bz - by * az;
    c[1] = bx * az - ax * bz;
    c[2] = ax * by - bx * ay;
    d = ax * bx + ay * by + az * bz;
    for (int i = 0; i < 3; i++) mag[i] = (c[i] < 0) ? -c[i] : c[i];
    mag[3] = (d < 0) ? -d : d;
    top = 0;
    for (int i = 0; i < 4; i++) if (mag[i] > top) top = mag[i];
    if (top == 0) return 16'd0;
    len = 0;
    while ((top >> len) != 0) len++;
    // Normalize all magnitudes together so the largest fills bits 30..0.
    for (int i = 0; i < 4; i++)
      mag[i] = (len > 31) ? (mag[i] >> (len - 31)) : (mag[i] << (31 - len));
    sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > sq) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (sq >= r + bitv) begin
        sq = sq - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    x = (d < 0) ? -longint'(mag[3]) : longint'(mag[3]);
    y = longint'(r);
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'sd2147483648;
    end
    for (int i = 0; i < Steps; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(atan_unit(i[4:0]));
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(atan_unit(i[4:0]));
      end
    end
    if (z < 0) z = 0;
    rnd = 64'sd1 << (32 - FracBits - 1);
    res = (z + rnd) >>> (32 - FracBits);
    if (res > (64'sd1 << FracBits)) res = 64'sd1 << FracBits;
    return res[15:0];
  endfunction

  assign pending = expected_angles.size();

  always @(posedge clk) begin
    if (rst) begin
      failures <= 0;
    end else begin
      if (push && !full)
        expected_angles.push_back(predict_angle(first_x, first_y, first_z,
                                                second_x, second_y, second_z));
      if (pop && !empty) begin
        if (expected_angles.size() == 0) begin
          $error("angle: result with no request waiting, actual %0d", angle);
          failures <= failures + 1;
        end else begin
          if (expected_angles[0] !== angle) begin
            $error("angle: expected %0d actual %0d", expected_angles[0], angle);
            failures <= failures + 1;
          end
          void'(expected_angles.pop_front());
        end
      end
    end
  end
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic signed [15:0] first_x = 0, first_y = 0, first_z = 0;
  logic signed [15:0] second_x = 0, second_y = 0, second_z = 0;
  logic full, empty;
  logic [15:0] angle;
  int failures, pending;
  int sent;
  bit sending_done = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  vector_angle_between dut (.*);
  angle_checker checker_inst (.*);

  function automatic logic [15:0] pick_component(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(logic [15:0] ax, ay, az, bx, by, bz);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap != 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    first_x <= ax; first_y <= ay; first_z <= az;
    second_x <= bx; second_y <= by; second_z <= bz;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] v[6];
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Zero vectors, parallel and antiparallel pairs, full-scale extremes.
    send_request(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(16'd0, 16'd0, 16'd0, 16'd5, 16'd6, 16'd7);
    send_request(16'd3, 16'd4, 16'd5, 16'd6, 16'd8, 16'd10);
    send_request(16'd3, 16'd4, 16'd5, -16'sd6, -16'sd8, -16'sd10);
    send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(16'h7fff, 16'd0, 16'd0, 16'd0, 16'h7fff, 16'd0);
    send_request(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
    send_request(16'd1, 16'd0, 16'd0, -16'sd1, 16'd1, 16'd0);
    send_request(16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
    send_request(16'hffff, 16'hffff, 16'hffff, 16'd1, 16'd1, 16'd1);
    send_request(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    // Let the pipeline drain completely before the random part.
    drain();
    for (int n = 0; n < 450; n++) begin
      for (int i = 0; i < 6; i++) v[i] = pick_component($urandom_range(0, 9));
      if ($urandom_range(0, 9) == 0) begin
        v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
        if ($urandom_range(0, 1)) begin
          v[3] = -v[0]; v[4] = -v[1]; v[5] = -v[2];
        end
      end
      send_request(v[0], v[1], v[2], v[3], v[4], v[5]);
      if (n == 200) drain();
    end
    push <= 0;
    @(posedge clk);
    sending_done = 1;
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 13);
      if (gap != 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    wait (sending_done);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d vector pairs: zero, parallel, antiparallel, full-scale", sent);
    $display("and random pairs under random push and pop gaps.");
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
